>>> design/assert_macros.svh
// Assertion macros shared by the parser RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, switched off while reset is asserted.
`define ASSERT_CLKD(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Clocked check that also holds through reset.
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

>>> design/ethip_pkg.sv
// Package of constants, types and classifiers for the header parser.
`timescale 1ns / 1ps

package ethip_pkg;

    localparam int HEADER_BYTES = 38;

    localparam logic [15:0] ETYPE_IPV4 = 16'h0800;
    localparam logic [15:0] ETYPE_ARP  = 16'h0806;
    localparam logic [15:0] ETYPE_RARP = 16'h8035;
    localparam logic [15:0] ETYPE_IPV6 = 16'h86DD;

    localparam logic [7:0] PROTO_ICMP   = 8'd1;
    localparam logic [7:0] PROTO_TCP    = 8'd6;
    localparam logic [7:0] PROTO_UDP    = 8'd17;
    localparam logic [7:0] PROTO_ICMPV6 = 8'd58;
    localparam logic [7:0] PROTO_STP    = 8'd118;
    localparam logic [7:0] PROTO_SMP    = 8'd121;

    localparam logic [2:0] ECLASS_IPV4  = 3'd0;
    localparam logic [2:0] ECLASS_ARP   = 3'd1;
    localparam logic [2:0] ECLASS_RARP  = 3'd2;
    localparam logic [2:0] ECLASS_IPV6  = 3'd3;
    localparam logic [2:0] ECLASS_OTHER = 3'd4;

    localparam logic [2:0] PCLASS_ICMP   = 3'd0;
    localparam logic [2:0] PCLASS_TCP    = 3'd1;
    localparam logic [2:0] PCLASS_UDP    = 3'd2;
    localparam logic [2:0] PCLASS_ICMPV6 = 3'd3;
    localparam logic [2:0] PCLASS_STP    = 3'd4;
    localparam logic [2:0] PCLASS_SMP    = 3'd5;
    localparam logic [2:0] PCLASS_OTHER  = 3'd6;

    localparam logic [1:0] STATUS_ICMP      = 2'd0;
    localparam logic [1:0] STATUS_IP_OTHER  = 2'd1;
    localparam logic [1:0] STATUS_NOT_IP    = 2'd2;
    localparam logic [1:0] STATUS_TRUNCATED = 2'd3;

    // Per-cycle control broadcast along the cell row.
    typedef struct packed {
        logic advance;
        logic last;
    } step_t;

    function automatic logic [2:0] ether_class_of(input logic [15:0] etype);
        logic [2:0] cls;
        case (etype)
            ETYPE_IPV4: cls = ECLASS_IPV4;
            ETYPE_ARP:  cls = ECLASS_ARP;
            ETYPE_RARP: cls = ECLASS_RARP;
            ETYPE_IPV6: cls = ECLASS_IPV6;
            default:    cls = ECLASS_OTHER;
        endcase
        return cls;
    endfunction

    function automatic logic [2:0] proto_class_of(input logic [7:0] proto);
        logic [2:0] cls;
        case (proto)
            PROTO_ICMP:   cls = PCLASS_ICMP;
            PROTO_TCP:    cls = PCLASS_TCP;
            PROTO_UDP:    cls = PCLASS_UDP;
            PROTO_ICMPV6: cls = PCLASS_ICMPV6;
            PROTO_STP:    cls = PCLASS_STP;
            PROTO_SMP:    cls = PCLASS_SMP;
            default:      cls = PCLASS_OTHER;
        endcase
        return cls;
    endfunction

endpackage

>>> design/ethip_cell.sv
// One byte cell of the capture row: holds a header byte and passes the write token on.
`timescale 1ns / 1ps

module ethip_cell
    import ethip_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  step_t      step,
    input  logic       tok_in,
    input  logic [7:0] data_in,
    output logic       tok_out,
    output logic [7:0] byte_view
);

    logic [7:0] byte_reg, byte_next;
    logic       tok_reg, tok_next;

    always_comb begin
        byte_next = byte_reg;
        tok_next  = tok_reg;
        if (step.advance) begin
            if (step.last) begin
                // frame done: drop the captured byte and the token
                byte_next = 8'd0;
                tok_next  = 1'b0;
            end else begin
                if (tok_in) begin
                    byte_next = data_in;
                end
                tok_next = tok_in;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_reg <= 8'd0;
            tok_reg  <= 1'b0;
        end else begin
            byte_reg <= byte_next;
            tok_reg  <= tok_next;
        end
    end

    // a byte arriving on a taken request is seen in the same cycle, also on the final request, where it is not stored
    assign byte_view = (step.advance && tok_in) ? data_in : byte_reg;
    assign tok_out   = tok_reg;

endmodule

>>> design/ethip_record.sv
// Field extraction, classification and the output register of the record.
`timescale 1ns / 1ps

module ethip_record
    import ethip_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  step_t       step,
    input  logic [7:0]  hdr [HEADER_BYTES],
    input  logic        truncated,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [47:0] m_dest_mac,
    output logic [47:0] m_source_mac,
    output logic [15:0] m_ether_type,
    output logic [2:0]  m_ether_class,
    output logic [31:0] m_ip_word_zero,
    output logic [31:0] m_ip_word_one,
    output logic [31:0] m_ip_word_two,
    output logic [31:0] m_ip_source,
    output logic [31:0] m_ip_dest,
    output logic [2:0]  m_proto_class,
    output logic [31:0] m_icmp_word,
    output logic [1:0]  m_parse_status
);

    logic        load;
    logic [15:0] etype;
    logic [2:0]  eclass, pclass;
    logic        is_ip, is_icmp;
    logic [1:0]  status;

    logic        valid_reg, valid_next;
    logic [47:0] dest_mac_reg, source_mac_reg;
    logic [15:0] ether_type_reg;
    logic [2:0]  ether_class_reg, proto_class_reg;
    logic [31:0] ip_word_zero_reg, ip_word_one_reg, ip_word_two_reg;
    logic [31:0] ip_source_reg, ip_dest_reg, icmp_word_reg;
    logic [1:0]  parse_status_reg;

    assign load    = step.advance && step.last;
    assign etype   = {hdr[12], hdr[13]};
    assign eclass  = ether_class_of(etype);
    assign is_ip   = (eclass == ECLASS_IPV4);
    assign pclass  = is_ip ? proto_class_of(hdr[23]) : PCLASS_OTHER;
    assign is_icmp = is_ip && (pclass == PCLASS_ICMP);

    always_comb begin
        if (truncated) begin
            status = STATUS_TRUNCATED;
        end else if (is_icmp) begin
            status = STATUS_ICMP;
        end else if (is_ip) begin
            status = STATUS_IP_OTHER;
        end else begin
            status = STATUS_NOT_IP;
        end
    end

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            dest_mac_reg     <= {hdr[0], hdr[1], hdr[2], hdr[3], hdr[4], hdr[5]};
            source_mac_reg   <= {hdr[6], hdr[7], hdr[8], hdr[9], hdr[10], hdr[11]};
            ether_type_reg   <= etype;
            ether_class_reg  <= eclass;
            ip_word_zero_reg <= is_ip ? {hdr[14], hdr[15], hdr[16], hdr[17]} : 32'd0;
            ip_word_one_reg  <= is_ip ? {hdr[18], hdr[19], hdr[20], hdr[21]} : 32'd0;
            ip_word_two_reg  <= is_ip ? {hdr[22], hdr[23], hdr[24], hdr[25]} : 32'd0;
            ip_source_reg    <= is_ip ? {hdr[26], hdr[27], hdr[28], hdr[29]} : 32'd0;
            ip_dest_reg      <= is_ip ? {hdr[30], hdr[31], hdr[32], hdr[33]} : 32'd0;
            proto_class_reg  <= pclass;
            icmp_word_reg    <= is_icmp ? {hdr[34], hdr[35], hdr[36], hdr[37]} : 32'd0;
            parse_status_reg <= status;
        end
    end

    assign m_valid        = valid_reg;
    assign m_dest_mac     = dest_mac_reg;
    assign m_source_mac   = source_mac_reg;
    assign m_ether_type   = ether_type_reg;
    assign m_ether_class  = ether_class_reg;
    assign m_ip_word_zero = ip_word_zero_reg;
    assign m_ip_word_one  = ip_word_one_reg;
    assign m_ip_word_two  = ip_word_two_reg;
    assign m_ip_source    = ip_source_reg;
    assign m_ip_dest      = ip_dest_reg;
    assign m_proto_class  = proto_class_reg;
    assign m_icmp_word    = icmp_word_reg;
    assign m_parse_status = parse_status_reg;

endmodule

>>> design/ethernet_ipv4_icmp_header_parser_core.sv
// Ethernet / IPv4 / ICMP header parser: one record per received frame.
// Input channel s_: one raw frame byte per request (s_data_byte), with
// s_frame_end high on the last byte of the frame. Bytes are taken one per
// cycle, back to back, across frame boundaries, while no frame end is held off.
// The first 38 bytes are written into a row of byte cells; a one-hot write
// token walks along the row, one cell per byte. Later bytes are dropped.
// Output channel m_: one record per frame, presented in the cycle after the
// request carrying s_frame_end is taken. The record holds the MACs, the
// ethertype and its class, the IPv4 words and addresses, the protocol class,
// the ICMP word and a status (truncated when fewer than 38 bytes arrived).
// Throughput: one byte per cycle while no frame end is held off; a one-byte
// frame can follow a record directly, so records can leave every cycle.
// Reset (aresetn low, synchronous): the row is cleared, the token returns to
// the first cell and any pending record is dropped.
// Receiver stall: the record waits in the output register; input bytes keep
// being taken while it waits, only a further request is held off if it
// would need the output register before the waiting record has gone.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ethernet_ipv4_icmp_header_parser_core
    import ethip_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    input  logic        s_frame_end,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [47:0] m_dest_mac,
    output logic [47:0] m_source_mac,
    output logic [15:0] m_ether_type,
    output logic [2:0]  m_ether_class,
    output logic [31:0] m_ip_word_zero,
    output logic [31:0] m_ip_word_one,
    output logic [31:0] m_ip_word_two,
    output logic [31:0] m_ip_source,
    output logic [31:0] m_ip_dest,
    output logic [2:0]  m_proto_class,
    output logic [31:0] m_icmp_word,
    output logic [1:0]  m_parse_status
);

    step_t                 step;
    logic [HEADER_BYTES:0] tok_chain;
    logic [7:0]            hdr_view [HEADER_BYTES];
    logic                  head_reg, head_next;
    logic                  full_reg, full_next;
    logic                  truncated;
    logic [HEADER_BYTES:0] token_map;
    logic                  frame_done;

    // only a frame end needs the output register to be free
    assign s_ready      = !m_valid || m_ready || !s_frame_end;
    assign step.advance = s_valid && s_ready;
    assign step.last    = s_frame_end;

    assign tok_chain[0] = head_reg;

    for (genvar i = 0; i < HEADER_BYTES; i++) begin : g_cell
        ethip_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .step      (step),
            .tok_in    (tok_chain[i]),
            .data_in   (s_data_byte),
            .tok_out   (tok_chain[i+1]),
            .byte_view (hdr_view[i])
        );
    end

    always_comb begin
        head_next = head_reg;
        full_next = full_reg | tok_chain[HEADER_BYTES];
        if (step.advance) begin
            head_next = step.last;
            if (step.last) begin
                full_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg <= 1'b1;
            full_reg <= 1'b0;
        end else begin
            head_reg <= head_next;
            full_reg <= full_next;
        end
    end

    // header complete once the last cell has been written, this cycle or before
    assign truncated = !(full_reg || tok_chain[HEADER_BYTES] || tok_chain[HEADER_BYTES-1]);

    ethip_record u_record (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .step           (step),
        .hdr            (hdr_view),
        .truncated      (truncated),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_dest_mac     (m_dest_mac),
        .m_source_mac   (m_source_mac),
        .m_ether_type   (m_ether_type),
        .m_ether_class  (m_ether_class),
        .m_ip_word_zero (m_ip_word_zero),
        .m_ip_word_one  (m_ip_word_one),
        .m_ip_word_two  (m_ip_word_two),
        .m_ip_source    (m_ip_source),
        .m_ip_dest      (m_ip_dest),
        .m_proto_class  (m_proto_class),
        .m_icmp_word    (m_icmp_word),
        .m_parse_status (m_parse_status)
    );

    assign token_map  = {head_reg, tok_chain[HEADER_BYTES-1:1],
                         full_reg | tok_chain[HEADER_BYTES]};
    assign frame_done = step.advance && step.last;

    `ASSERT_CLKD(a_token_onehot, $onehot(token_map), "write token not one-hot")
    `ASSERT_CLKD(a_head_after_end, frame_done |=> head_reg, "token not back at first cell")
    `ASSERT_CLKD(a_record_from_end, $rose(m_valid) |-> $past(frame_done), "record without frame end")

endmodule
